### rtl/fsd_pkg.sv
// Shared types, constants and helper functions for the binary error-diffusion dither.
// No dependencies; every other file of the block imports this package.
package fsd_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 256;
	localparam int unsigned MAX_HEIGHT_DEF = 256;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int ERR_W     = PIX_W;
	localparam int WGT_W     = 4;
	localparam int PROD_W    = ERR_W + WGT_W - 1;
	localparam int SHARE_SHIFT = 4;
	localparam int ROUND_BIAS  = (1 << SHARE_SHIFT) - 1;

	localparam int unsigned PIX_MAX    = 255;
	localparam int unsigned RESET_DIM  = 200;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DITHER = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CTR,
		S_NRD,
		S_NWR,
		S_DONE
	} fsd_state_t;

	typedef enum logic [1:0] {
		NB_RIGHT,
		NB_BELOW_LEFT,
		NB_BELOW,
		NB_BELOW_RIGHT
	} fsd_nb_t;

	// Diffusion weight of each neighbour, in sixteenths.
	function automatic logic [WGT_W-1:0] nb_weight(fsd_nb_t nb);
		logic [WGT_W-1:0] w;
		case (nb)
			NB_RIGHT:       w = 4'd7;
			NB_BELOW_LEFT:  w = 4'd3;
			NB_BELOW:       w = 4'd5;
			NB_BELOW_RIGHT: w = 4'd1;
			default:        w = 4'd0;
		endcase
		return w;
	endfunction

	// Effective dimension minus one: zero acts as one, anything above the maximum as the maximum.
	function automatic logic [31:0] dim_m1(logic [CFG_W-1:0] v, int unsigned maxv);
		logic [31:0] r;
		if (v == '0)
			r = '0;
		else if (32'(v) > maxv)
			r = maxv - 1;
		else
			r = 32'(v) - 32'd1;
		return r;
	endfunction

endpackage

### rtl/fsd_if.sv
// Valid/ready channel interfaces for the dither block: command input and result output.
// Depends on fsd_pkg for the payload widths.
interface fsd_in_if import fsd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output cmd, output pixel_in, input ready);
	modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface fsd_out_if import fsd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             last_of_frame;
	logic             seq_error;

	modport source (output valid, output pixel_out, output last_of_frame, output seq_error,
		input ready);
	modport sink   (input valid, input pixel_out, input last_of_frame, input seq_error,
		output ready);
endinterface

### rtl/fsd_diffuse.sv
// Shared arithmetic unit: adds one weighted share of the quantisation error to a pixel.
// Depends on fsd_pkg for widths and rounding constants.
module fsd_diffuse import fsd_pkg::*; (
	input  logic signed [ERR_W-1:0] err,
	input  logic        [WGT_W-1:0] weight,
	input  logic        [PIX_W-1:0] pix,
	output logic        [PIX_W-1:0] result
);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] share;
	logic signed [PROD_W-1:0] sum;

	always_comb begin
		prod = PROD_W'(err) * $signed({{(PROD_W-WGT_W){1'b0}}, weight});
		// The arithmetic shift floors, so negative products are biased first to truncate toward zero.
		if (prod < 0)
			share = (prod + PROD_W'(ROUND_BIAS)) >>> SHARE_SHIFT;
		else
			share = prod >>> SHARE_SHIFT;
		sum = $signed({{(PROD_W-PIX_W){1'b0}}, pix}) + share;
		if (sum < 0)
			result = '0;
		else if (sum > $signed(PROD_W'(PIX_MAX)))
			result = PIX_W'(PIX_MAX);
		else
			result = sum[PIX_W-1:0];
	end

endmodule

### rtl/floyd_steinberg_binary_dither_top.sv
// Binary error-diffusion dither with an on-chip frame store and a single shared update unit.
// A load or ignored command registers its result at its transfer; a dither goes through S_CTR,
// S_NRD for each neighbour with S_NWR after each one inside the frame, and S_DONE, which waits
// for a free result slot; no command is taken meanwhile. Throughput: one load per cycle while
// the result slot is free, as the next command can transfer with the result. Reset clears position,
// phase and result valid, sets both sizes to 200, leaves the store uncleared. Uses fsd_pkg/if/diffuse.
module floyd_steinberg_binary_dither_top import fsd_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fsd_in_if.sink               in_ch,
	fsd_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;

	// Frame store, addressed by row and column with a fixed row pitch.
	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_q;

	fsd_state_t state_q, state_d;
	fsd_nb_t    nb_q;
	logic [XW-1:0] x_q, wm1_q;
	logic [YW-1:0] y_q, hm1_q;
	logic          loaded_q;
	logic signed [ERR_W-1:0] err_q;
	logic [PIX_W-1:0] nw_q;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             out_last_q;
	logic             out_err_q;

	logic             slot_free;
	logic             in_xfer;
	logic             cmd_ok;
	logic             last_pos;
	logic             advance;
	logic             cfg_hit;

	logic             rd_en, wr_en;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic [PIX_W-1:0] wr_data;

	logic             res_set;
	logic [PIX_W-1:0] res_pixel;
	logic             res_last;
	logic             res_err;

	logic             ctr_cap;
	logic             nb_step;
	logic             nb_en;
	logic [AW-1:0]    nb_addr;
	logic [PIX_W-1:0] upd_pix;
	logic [PIX_W-1:0] ctr_nw;
	logic signed [PIX_W:0] ctr_err;

	fsd_diffuse u_diffuse (
		.err    (err_q),
		.weight (nb_weight(nb_q)),
		.pix    (rd_q),
		.result (upd_pix)
	);

	assign slot_free = !out_valid_q || out_ch.ready;
	assign in_xfer   = in_ch.valid && in_ch.ready;
	assign cmd_ok    = (in_ch.cmd == CMD_DITHER) == loaded_q;
	assign last_pos  = (x_q == wm1_q) && (y_q == hm1_q);
	assign cfg_hit   = cfg_we && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT);

	assign ctr_nw  = rd_q[PIX_W-1] ? PIX_W'(PIX_MAX) : '0;
	assign ctr_err = $signed({1'b0, rd_q}) - $signed({1'b0, ctr_nw});

	// Neighbour address and whether it lies inside the frame.
	always_comb begin
		nb_en   = 1'b0;
		nb_addr = {y_q, x_q};
		case (nb_q)
			NB_RIGHT: begin
				nb_en   = x_q != wm1_q;
				nb_addr = {y_q, x_q + XW'(1)};
			end
			NB_BELOW_LEFT: begin
				nb_en   = (y_q != hm1_q) && (x_q != '0);
				nb_addr = {y_q + YW'(1), x_q - XW'(1)};
			end
			NB_BELOW: begin
				nb_en   = y_q != hm1_q;
				nb_addr = {y_q + YW'(1), x_q};
			end
			NB_BELOW_RIGHT: begin
				nb_en   = (y_q != hm1_q) && (x_q != wm1_q);
				nb_addr = {y_q + YW'(1), x_q + XW'(1)};
			end
			default: begin
				nb_en   = 1'b0;
				nb_addr = {y_q, x_q};
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = {y_q, x_q};
		wr_en       = 1'b0;
		wr_addr     = {y_q, x_q};
		wr_data     = in_ch.pixel_in;
		res_set     = 1'b0;
		res_pixel   = '0;
		res_last    = 1'b0;
		res_err     = 1'b0;
		advance     = 1'b0;
		ctr_cap     = 1'b0;
		nb_step     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ch.ready = slot_free;
				if (in_xfer) begin
					if (!cmd_ok) begin
						res_set = 1'b1;
						res_err = 1'b1;
					end else if (in_ch.cmd == CMD_LOAD) begin
						wr_en    = 1'b1;
						res_set  = 1'b1;
						res_last = last_pos;
						advance  = 1'b1;
					end else begin
						rd_en   = 1'b1;
						state_d = S_CTR;
					end
				end
			end
			S_CTR: begin
				ctr_cap = 1'b1;
				wr_en   = 1'b1;
				wr_data = ctr_nw;
				state_d = S_NRD;
			end
			S_NRD: begin
				if (nb_en) begin
					rd_en   = 1'b1;
					rd_addr = nb_addr;
					state_d = S_NWR;
				end else begin
					nb_step = 1'b1;
					state_d = (nb_q == NB_BELOW_RIGHT) ? S_DONE : S_NRD;
				end
			end
			S_NWR: begin
				wr_en   = 1'b1;
				wr_addr = nb_addr;
				wr_data = upd_pix;
				nb_step = 1'b1;
				state_d = (nb_q == NB_BELOW_RIGHT) ? S_DONE : S_NRD;
			end
			S_DONE: begin
				if (slot_free) begin
					res_set   = 1'b1;
					res_pixel = nw_q;
					res_last  = last_pos;
					advance   = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nb_q    <= NB_RIGHT;
		end else begin
			state_q <= state_d;
			if (ctr_cap)
				nb_q <= NB_RIGHT;
			else if (nb_step)
				nb_q <= fsd_nb_t'(nb_q + 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q    <= XW'(dim_m1(CFG_W'(RESET_DIM), MAX_WIDTH));
			hm1_q    <= YW'(dim_m1(CFG_W'(RESET_DIM), MAX_HEIGHT));
			x_q      <= '0;
			y_q      <= '0;
			loaded_q <= 1'b0;
		end else begin
			case (cfg_we ? cfg_idx : ~REG_FRAME_WIDTH & ~REG_FRAME_HEIGHT)
				REG_FRAME_WIDTH:  wm1_q <= XW'(dim_m1(cfg_wdata, MAX_WIDTH));
				REG_FRAME_HEIGHT: hm1_q <= YW'(dim_m1(cfg_wdata, MAX_HEIGHT));
				default: ;
			endcase
			if (cfg_hit) begin
				x_q      <= '0;
				y_q      <= '0;
				loaded_q <= 1'b0;
			end else if (advance) begin
				if (last_pos) begin
					x_q      <= '0;
					y_q      <= '0;
					loaded_q <= !loaded_q;
				end else if (x_q == wm1_q) begin
					x_q <= '0;
					y_q <= y_q + YW'(1);
				end else begin
					x_q <= x_q + XW'(1);
				end
			end
		end
	end

	// Quantised centre value and its error, kept for the neighbour updates.
	always_ff @(posedge clk) begin
		if (ctr_cap) begin
			nw_q  <= ctr_nw;
			err_q <= ctr_err[ERR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	// Result register: a new result may be loaded in the cycle the old one transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_set)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_set) begin
			out_pixel_q <= res_pixel;
			out_last_q  <= res_last;
			out_err_q   <= res_err;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.pixel_out     = out_pixel_q;
	assign out_ch.last_of_frame = out_last_q;
	assign out_ch.seq_error     = out_err_q;

endmodule

### sim/tb_floyd_steinberg_binary_dither_top.sv
`timescale 1ns / 100ps
// Testbench for floyd_steinberg_binary_dither_top. A short table of directed commands runs
// first, then random frames with random valid/ready gaps, checked against a local dither or a row's given result.
// Depends on fsd_pkg, the fsd_in_if and fsd_out_if interfaces and the block's RTL.
module tb_floyd_steinberg_binary_dither_top;
	import fsd_pkg::*;

	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 2;
	localparam int unsigned DRAIN_CYCLES  = 16;
	localparam int unsigned STORE_DEPTH   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

	// Register indexes that select nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// Gap percentages of sender and receiver, and the command count that ends each stretch.
	localparam int unsigned TX_IDLE [3]  = '{27, 85, 0};
	localparam int unsigned RX_IDLE [3]  = '{85, 27, 0};
	localparam int unsigned CMD_GOAL [3] = '{340, 600, 880};

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             last_of_frame;
		logic             seq_error;
	} dither_res_t;

	typedef enum logic {ROW_WRITE, ROW_CMD} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic                 cmd;
		logic [PIX_W-1:0]     pix;
		bit                   known;
		dither_res_t          res;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 rx_ready = 1'b0;

	fsd_in_if  in_ch ();
	fsd_out_if out_ch ();

	assign out_ch.ready = rx_ready;

	floyd_steinberg_binary_dither_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Local copy of the frame, the registers and the raster position.
	logic [PIX_W-1:0] frame_px [STORE_DEPTH];
	logic [CFG_W-1:0] width_reg  = CFG_W'(RESET_DIM);
	logic [CFG_W-1:0] height_reg = CFG_W'(RESET_DIM);
	int unsigned      cur_col = 0;
	int unsigned      cur_row = 0;
	bit               in_dither_phase = 1'b0;

	dither_res_t results_due [$];

	int unsigned tx_idle_pct  = 0;
	int unsigned rx_idle_pct  = 0;
	int unsigned fails        = 0;
	int unsigned cmds_sent    = 0;
	int unsigned results_seen = 0;
	int unsigned px_dithered  = 0;
	int unsigned ignored_cmds = 0;
	int unsigned frames_done  = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned maxv);
		int unsigned d;
		d = v;
		if (d == 0)
			d = 1;
		else if (d > maxv)
			d = maxv;
		return d;
	endfunction

	// Adds k/16 of the error to one neighbour, truncated toward zero, then clamps.
	function automatic void spread_share(int unsigned idx, int err, int k);
		int v;
		v = int'(frame_px[idx]) + (err * k) / 16;
		if (v < 0)
			v = 0;
		else if (v > int'(PIX_MAX))
			v = int'(PIX_MAX);
		frame_px[idx] = v[PIX_W-1:0];
	endfunction

	function automatic dither_res_t dither_cmd_step(logic cmd, logic [PIX_W-1:0] pix);
		dither_res_t r;
		int unsigned w, h, x, y, idx;
		int          old_px, new_px, err;
		bit          last;
		r = '0;
		w = eff_dim(width_reg, MAX_WIDTH_DEF);
		h = eff_dim(height_reg, MAX_HEIGHT_DEF);
		x = cur_col;
		y = cur_row;
		if ((cmd == CMD_DITHER) != in_dither_phase) begin
			r.seq_error = 1'b1;
			ignored_cmds++;
			return r;
		end
		idx = y * w + x;
		if (cmd == CMD_LOAD) begin
			frame_px[idx] = pix;
		end else begin
			old_px = int'(frame_px[idx]);
			new_px = (old_px < 128) ? 0 : int'(PIX_MAX);
			err = old_px - new_px;
			frame_px[idx] = new_px[PIX_W-1:0];
			r.pixel_out = new_px[PIX_W-1:0];
			px_dithered++;
			if (x + 1 < w)
				spread_share(idx + 1, err, 7);
			if (y + 1 < h) begin
				if (x > 0)
					spread_share(idx + w - 1, err, 3);
				spread_share(idx + w, err, 5);
				if (x + 1 < w)
					spread_share(idx + w + 1, err, 1);
			end
		end
		last = (x + 1 >= w) && (y + 1 >= h);
		r.last_of_frame = last;
		if (last) begin
			if (in_dither_phase)
				frames_done++;
			cur_col = 0;
			cur_row = 0;
			in_dither_phase = !in_dither_phase;
		end else if (x + 1 >= w) begin
			cur_col = 0;
			cur_row = y + 1;
		end else begin
			cur_col = x + 1;
		end
		return r;
	endfunction

	function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		script_row_t r;
		r = '{ROW_WRITE, idx, data, CMD_LOAD, '0, 1'b0, '0};
		return r;
	endfunction

	function automatic script_row_t cmd_row(logic cmd, logic [PIX_W-1:0] pix, bit known,
		logic [PIX_W-1:0] px_out, logic last, logic seq);
		script_row_t r;
		r = '{ROW_CMD, '0, '0, cmd, pix, known, '{px_out, last, seq}};
		return r;
	endfunction

	// Entered and left just after a rising edge; valid stays high when no gap follows.
	task automatic send_cmd(input logic cmd, input logic [PIX_W-1:0] pix, input bit known,
		input dither_res_t known_res);
		dither_res_t r;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_ch.valid    <= 1'b1;
		in_ch.cmd      <= cmd;
		in_ch.pixel_in <= pix;
		do @(negedge clk); while (!in_ch.ready);
		// The transfer takes place at the coming rising edge.
		r = dither_cmd_step(cmd, pix);
		results_due.push_back(known ? known_res : r);
		cmds_sent++;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		in_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		// The block is idle once every result has left; a short gap still precedes the write.
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:  width_reg  = data;
			REG_FRAME_HEIGHT: height_reg = data;
			default: ;
		endcase
		if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
			cur_col = 0;
			cur_row = 0;
			in_dither_phase = 1'b0;
		end
	endtask

	task automatic run_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
		input int unsigned dither_cap);
		bit               wr_w, wr_h;
		int unsigned      npix, nload, ndith, style;
		logic [PIX_W-1:0] px;
		wr_w = (w_val != width_reg) || ($urandom_range(3) == 0);
		wr_h = (h_val != height_reg) || ($urandom_range(3) == 0);
		// A new frame has to start at the first pixel of the loading phase.
		if (!wr_w && !wr_h && (in_dither_phase || cur_col != 0 || cur_row != 0))
			wr_h = 1'b1;
		if (wr_w)
			write_reg(REG_FRAME_WIDTH, w_val);
		if (wr_h)
			write_reg(REG_FRAME_HEIGHT, h_val);
		if ($urandom_range(7) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
		npix = eff_dim(w_val, MAX_WIDTH_DEF) * eff_dim(h_val, MAX_HEIGHT_DEF);
		nload = npix;
		// Now and then the load is cut short and the next frame starts afresh.
		if ($urandom_range(11) == 0)
			nload = $urandom_range(npix - 1);
		style = $urandom_range(3);
		for (int unsigned i = 0; i < nload; i++) begin
			if ($urandom_range(99) < 6)
				send_cmd(CMD_DITHER, PIX_W'($urandom), 1'b0, '0);
			case (style)
				0: px = PIX_W'($urandom);
				1: begin
					case ($urandom_range(3))
						0: px = 8'd0;
						1: px = 8'd255;
						2: px = 8'd127;
						default: px = 8'd128;
					endcase
				end
				2: px = PIX_W'($urandom_range(143, 112));
				default: px = $urandom_range(1) ? PIX_W'($urandom_range(20)) :
					PIX_W'($urandom_range(255, 235));
			endcase
			send_cmd(CMD_LOAD, px, 1'b0, '0);
		end
		if (nload < npix)
			return;
		ndith = (npix < dither_cap) ? npix : dither_cap;
		if ($urandom_range(11) == 0)
			ndith = $urandom_range(ndith);
		for (int unsigned i = 0; i < ndith; i++) begin
			if ($urandom_range(99) < 6)
				send_cmd(CMD_LOAD, PIX_W'($urandom), 1'b0, '0);
			send_cmd(CMD_DITHER, PIX_W'($urandom), 1'b0, '0);
		end
	endtask

	always @(posedge clk)
		rx_ready <= ($urandom_range(99) >= rx_idle_pct);

	always @(negedge clk) begin
		dither_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (results_due.size() == 0) begin
				$error("result with no command outstanding: pixel_out %0d last %0b seq_error %0b",
					out_ch.pixel_out, out_ch.last_of_frame, out_ch.seq_error);
				fails++;
			end else begin
				want = results_due.pop_front();
				if (out_ch.pixel_out !== want.pixel_out) begin
					$error("pixel_out: expected %0d, got %0d", want.pixel_out, out_ch.pixel_out);
					fails++;
				end
				if (out_ch.last_of_frame !== want.last_of_frame) begin
					$error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
						out_ch.last_of_frame);
					fails++;
				end
				if (out_ch.seq_error !== want.seq_error) begin
					$error("seq_error: expected %0b, got %0b", want.seq_error, out_ch.seq_error);
					fails++;
				end
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("No transfer on either channel for %0d cycles.", STALL_LIMIT);
		$display("floyd_steinberg_binary_dither_top test failed");
		$finish;
	end

	initial begin
		script_row_t      script [$];
		int unsigned      directed_cmds;
		logic [CFG_W-1:0] w_pick, h_pick;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = '0;
		cfg_wdata      = '0;
		in_ch.valid    = 1'b0;
		in_ch.cmd      = CMD_LOAD;
		in_ch.pixel_in = '0;
		tx_idle_pct    = TX_IDLE[0];
		rx_idle_pct    = RX_IDLE[0];

		script.push_back(cmd_row(CMD_DITHER, 8'h5A, 1'b1, 8'd0, 1'b0, 1'b1));
		script.push_back(reg_row(REG_FRAME_WIDTH, 9'd3));
		script.push_back(reg_row(REG_FRAME_HEIGHT, 9'd2));
		// This 3x2 frame drives neighbours past the lower clamp and gives negative errors.
		script.push_back(cmd_row(CMD_LOAD, 8'd255, 1'b1, 8'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(CMD_LOAD, 8'd128, 1'b1, 8'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(CMD_LOAD, 8'd127, 1'b1, 8'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(CMD_LOAD, 8'd0, 1'b1, 8'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(CMD_LOAD, 8'd200, 1'b1, 8'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(CMD_LOAD, 8'd1, 1'b1, 8'd0, 1'b1, 1'b0));
		script.push_back(cmd_row(CMD_LOAD, 8'h33, 1'b1, 8'd0, 1'b0, 1'b1));
		repeat (6) script.push_back(cmd_row(CMD_DITHER, 8'hFF, 1'b0, 8'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(CMD_DITHER, 8'h00, 1'b1, 8'd0, 1'b0, 1'b1));
		// Zero in both registers gives a single-pixel frame.
		script.push_back(reg_row(REG_FRAME_WIDTH, 9'd0));
		script.push_back(reg_row(REG_FRAME_HEIGHT, 9'd0));
		script.push_back(cmd_row(CMD_LOAD, 8'd77, 1'b1, 8'd0, 1'b1, 1'b0));
		script.push_back(cmd_row(CMD_DITHER, 8'd0, 1'b1, 8'd0, 1'b1, 1'b0));
		// Writes to the spare indexes must not disturb the position mid-frame.
		script.push_back(reg_row(REG_FRAME_WIDTH, 9'd2));
		script.push_back(reg_row(REG_FRAME_HEIGHT, 9'd1));
		script.push_back(cmd_row(CMD_LOAD, 8'd200, 1'b1, 8'd0, 1'b0, 1'b0));
		script.push_back(reg_row(REG_SPARE_2, 9'h1FF));
		script.push_back(reg_row(REG_SPARE_3, 9'h0AA));
		script.push_back(cmd_row(CMD_LOAD, 8'd50, 1'b1, 8'd0, 1'b1, 1'b0));
		// A register write during the dithering phase drops back to loading.
		script.push_back(reg_row(REG_FRAME_HEIGHT, 9'd1));
		script.push_back(cmd_row(CMD_DITHER, 8'd9, 1'b1, 8'd0, 1'b0, 1'b1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE)
				write_reg(script[i].idx, script[i].data);
			else
				send_cmd(script[i].cmd, script[i].pix, script[i].known, script[i].res);
		end
		directed_cmds = cmds_sent;

		for (int m = 0; m < 3; m++) begin
			tx_idle_pct = TX_IDLE[m];
			rx_idle_pct = RX_IDLE[m];
			// Registers at or above the store limits act as those limits; only the first pixels are dithered.
			if (m == 0)
				run_frame(9'h1FF, 9'd1, 2);
			if (m == 2)
				run_frame(9'd1, 9'd256, 2);
			while (cmds_sent < CMD_GOAL[m]) begin
				if ($urandom_range(11) == 0) begin
					w_pick = CFG_W'($urandom_range(24, 9));
					h_pick = CFG_W'($urandom_range(3, 1));
				end else begin
					w_pick = CFG_W'($urandom_range(9));
					h_pick = CFG_W'($urandom_range(7));
				end
				run_frame(w_pick, h_pick, 1000);
			end
		end

		in_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands (%0d directed): %0d pixels dithered, %0d frames finished,",
			cmds_sent, directed_cmds, px_dithered, frames_done);
		$display("%0d out-of-sequence commands, %0d results compared under three gap patterns.",
			ignored_cmds, results_seen);
		if (fails == 0)
			$display("floyd_steinberg_binary_dither_top test passed");
		else
			$display("floyd_steinberg_binary_dither_top test failed");
		$finish;
	end

endmodule
